>>> rtl/core/plcg_pkg.sv
// ----------------------------------------------------------------------------
// plcg_pkg
// Shared types and constants for the particle link contact generator.
// ----------------------------------------------------------------------------
package plcg_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NORM_FRAC  = 14;
  localparam int SUM_W      = 66;
  localparam int ROOT_W     = 34;
  localparam int NUM_W      = 32 + NORM_FRAC;
  localparam int QUOT_W     = NORM_FRAC + 1;
  localparam int PEN_W      = 33;
  localparam int BOUNCE_W   = 17;

  localparam logic [BOUNCE_W-1:0] BOUNCE_ONE = BOUNCE_W'(1 << FRAC_BITS);
  localparam logic [31:0] REST_RESET   = 32'(1 << FRAC_BITS);
  localparam logic [BOUNCE_W-1:0] BOUNCE_RESET = BOUNCE_W'(1 << (FRAC_BITS - 1));

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_REST   = 2'd1;
  localparam logic [1:0] REG_BOUNCE = 2'd2;

  // Side data carried along the square-root chain.
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             hit;
    logic             flip;
  } sq_side_t;

  // Side data carried along the divider chain.
  typedef struct packed {
    logic [2:0]       neg;
    logic             hit;
    logic [PEN_W-1:0] pen;
  } dv_side_t;

endpackage

>>> rtl/core/particle_link_contact_generator_core.sv
// ----------------------------------------------------------------------------
// particle_link_contact_generator_core
// Cable and rod contact generation for a pair of linked particles.
// ----------------------------------------------------------------------------
// The block accepts one item every clock cycle (busy is always low) and
// produces at most one result per item, strobed on out_valid for one cycle.
// The result path runs through the square-root chain (one cell per root
// bit, 34 cells) and the divider chain (one cell per normal bit, 15 cells)
// plus five stages around them. Items that make no contact produce no
// strobe. Results cannot be held off.
module particle_link_contact_generator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [31:0]                  in_first_x,
  input  logic signed [31:0]                  in_first_y,
  input  logic signed [31:0]                  in_first_z,
  input  logic signed [31:0]                  in_second_x,
  input  logic signed [31:0]                  in_second_y,
  input  logic signed [31:0]                  in_second_z,
  output logic                                out_valid,
  output logic signed [15:0]                  out_normal_x,
  output logic signed [15:0]                  out_normal_y,
  output logic signed [15:0]                  out_normal_z,
  output logic [plcg_pkg::PEN_W-1:0]          out_penetration,
  output logic [plcg_pkg::BOUNCE_W-1:0]       out_contact_restitution,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import plcg_pkg::*;

  localparam int NSQ = ROOT_W;
  localparam int NDV = QUOT_W;

  // Configuration registers.
  logic                cfg_link_mode_r;
  logic [31:0]         cfg_rest_length_r;
  logic [BOUNCE_W-1:0] cfg_bounce_factor_r;
  logic [63:0]         rest_sq_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_link_mode_r     <= 1'b0;
      cfg_rest_length_r   <= REST_RESET;
      cfg_bounce_factor_r <= BOUNCE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MODE:   cfg_link_mode_r     <= pwdata[0];
        REG_REST:   cfg_rest_length_r   <= pwdata;
        REG_BOUNCE: cfg_bounce_factor_r <= pwdata[BOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (paddr[3:2])
      REG_MODE:   prdata = {31'd0, cfg_link_mode_r};
      REG_REST:   prdata = cfg_rest_length_r;
      REG_BOUNCE: prdata = 32'(cfg_bounce_factor_r);
      default:    prdata = 32'd0;
    endcase
  end

  // Squared link length used for the contact decision.
  always_ff @(posedge clk) begin
    rest_sq_r <= 64'(cfg_rest_length_r) * 64'(cfg_rest_length_r);
  end

  // Stage 1: offsets and magnitudes.
  logic             v1_r;
  logic [2:0][31:0] mag1_r;
  logic [2:0]       neg1_r;
  logic [2:0][32:0] dif;
  logic             accept;

  assign accept = start & ~busy;

  always_comb begin
    dif[0] = {in_second_x[31], in_second_x} - {in_first_x[31], in_first_x};
    dif[1] = {in_second_y[31], in_second_y} - {in_first_y[31], in_first_y};
    dif[2] = {in_second_z[31], in_second_z} - {in_first_z[31], in_first_z};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag1_r[i] <= dif[i][32] ? 32'(-dif[i]) : dif[i][31:0];
      neg1_r[i] <= dif[i][32];
    end
  end

  // Stage 2: squares.
  logic             v2_r;
  logic [2:0][63:0] sq2_r;
  logic [2:0][31:0] mag2_r;
  logic [2:0]       neg2_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq2_r[i] <= 64'(mag1_r[i]) * 64'(mag1_r[i]);
    end
    mag2_r <= mag1_r;
    neg2_r <= neg1_r;
  end

  // Stage 3: sum of squares and contact decision.
  logic             v3_r;
  logic [SUM_W-1:0] sum3_r;
  sq_side_t         side3_r;
  logic [SUM_W-1:0] sum_nxt;
  logic             gt, eq;

  always_comb begin
    sum_nxt = SUM_W'(sq2_r[0]) + SUM_W'(sq2_r[1]) + SUM_W'(sq2_r[2]);
    gt      = sum_nxt > SUM_W'(rest_sq_r);
    eq      = sum_nxt == SUM_W'(rest_sq_r);
  end

  always_ff @(posedge clk) begin
    sum3_r       <= sum_nxt;
    side3_r.mag  <= mag2_r;
    side3_r.neg  <= neg2_r;
    side3_r.hit  <= cfg_link_mode_r ? ~eq : (gt | eq);
    side3_r.flip <= cfg_link_mode_r & ~gt & ~eq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Square-root chain, most significant root bit first.
  logic                  sq_vld  [0:NSQ];
  logic [SUM_W-1:0]      sq_rem  [0:NSQ];
  logic [ROOT_W-1:0]     sq_root [0:NSQ];
  sq_side_t              sq_side [0:NSQ];

  assign sq_vld[0]  = v3_r;
  assign sq_rem[0]  = sum3_r;
  assign sq_root[0] = '0;
  assign sq_side[0] = side3_r;

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    plcg_sqrt_cell #(.BIT(NSQ - 1 - k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (sq_vld[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .side_i (sq_side[k]),
      .vld_o  (sq_vld[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  // Stage 4: penetration and divider setup.
  logic                  v4_r;
  logic [ROOT_W-1:0]     len4_r;
  logic [2:0][NUM_W-1:0] num4_r;
  dv_side_t              side4_r;
  sq_side_t              sqo;
  logic [ROOT_W-1:0]     len;

  assign sqo = sq_side[NSQ];
  assign len = sq_root[NSQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= sq_vld[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    len4_r <= len;
    for (int i = 0; i < 3; i++) begin
      num4_r[i] <= {sqo.mag[i], NORM_FRAC'(0)};
    end
    side4_r.neg <= sqo.neg ^ {3{sqo.flip}};
    side4_r.hit <= sqo.hit;
    side4_r.pen <= sqo.flip ? PEN_W'({2'b00, cfg_rest_length_r} - len)
                            : PEN_W'(len - {2'b00, cfg_rest_length_r});
  end

  // Divider chain for the three normal components.
  logic                    dv_vld [0:NDV];
  logic [ROOT_W-1:0]       dv_len [0:NDV];
  logic [2:0][NUM_W-1:0]   dv_rem [0:NDV];
  logic [2:0][QUOT_W-1:0]  dv_q   [0:NDV];
  dv_side_t                dv_side[0:NDV];

  assign dv_vld[0]  = v4_r;
  assign dv_len[0]  = len4_r;
  assign dv_rem[0]  = num4_r;
  assign dv_q[0]    = '0;
  assign dv_side[0] = side4_r;

  for (genvar k = 0; k < NDV; k++) begin : g_div
    plcg_div_cell #(.BIT(NDV - 1 - k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (dv_vld[k]),
      .len_i  (dv_len[k]),
      .rem_i  (dv_rem[k]),
      .q_i    (dv_q[k]),
      .side_i (dv_side[k]),
      .vld_o  (dv_vld[k+1]),
      .len_o  (dv_len[k+1]),
      .rem_o  (dv_rem[k+1]),
      .q_o    (dv_q[k+1]),
      .side_o (dv_side[k+1])
    );
  end

  // Output stage: sign the normal and strobe contacts.
  logic                 out_valid_r;
  logic [2:0][15:0]     norm_r;
  logic [PEN_W-1:0]     pen_r;
  logic [BOUNCE_W-1:0]  rest_r;
  logic [2:0][15:0]     norm_nxt;
  dv_side_t             dvo;

  assign dvo = dv_side[NDV];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_len[NDV] == '0) begin
        norm_nxt[i] = 16'd0;
      end else if (dvo.neg[i]) begin
        norm_nxt[i] = 16'(-{1'b0, dv_q[NDV][i]});
      end else begin
        norm_nxt[i] = 16'(dv_q[NDV][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld[NDV] & dvo.hit;
    end
  end

  always_ff @(posedge clk) begin
    norm_r <= norm_nxt;
    pen_r  <= dvo.pen;
    if (cfg_link_mode_r) begin
      rest_r <= '0;
    end else if (cfg_bounce_factor_r > BOUNCE_ONE) begin
      rest_r <= BOUNCE_ONE;
    end else begin
      rest_r <= cfg_bounce_factor_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_normal_x            = norm_r[0];
  assign out_normal_y            = norm_r[1];
  assign out_normal_z            = norm_r[2];
  assign out_penetration         = pen_r;
  assign out_contact_restitution = rest_r;

  // Checks.
  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(dv_vld[NDV]))
    else $error("result strobe without an item leaving the divider");

  a_norm_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_normal_x) <= 16384 && $signed(out_normal_x) >= -16384))
    else $error("normal x out of range");

  a_norm_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_normal_y) <= 16384 && $signed(out_normal_y) >= -16384))
    else $error("normal y out of range");

  a_sqrt_entry: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##2 v3_r)
    else $error("accepted item did not reach the square-root chain");

  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (dv_len[0] <= ROOT_W'({ROOT_W{1'b1}})))
    else $error("root width overflow");

endmodule

>>> rtl/core/plcg_sqrt_cell.sv
// ----------------------------------------------------------------------------
// plcg_sqrt_cell
// One bit of the square-root chain: trial subtract and register.
// ----------------------------------------------------------------------------
module plcg_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic [plcg_pkg::SUM_W-1:0]    rem_i,
  input  logic [plcg_pkg::ROOT_W-1:0]   root_i,
  input  plcg_pkg::sq_side_t            side_i,
  output logic                          vld_o,
  output logic [plcg_pkg::SUM_W-1:0]    rem_o,
  output logic [plcg_pkg::ROOT_W-1:0]   root_o,
  output plcg_pkg::sq_side_t            side_o
);
  import plcg_pkg::*;

  localparam int TW = SUM_W + 2;

  logic [TW-1:0]     trial;
  logic              take;
  logic [SUM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic              vld_r;
  logic [SUM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  sq_side_t          side_r;

  // Growing the root by this bit costs (root << (BIT+1)) + 2^(2*BIT).
  always_comb begin
    trial    = (TW'(root_i) << (BIT + 1)) | (TW'(1) << (2 * BIT));
    take     = {2'b00, rem_i} >= trial;
    rem_nxt  = take ? SUM_W'({2'b00, rem_i} - trial) : rem_i;
    root_nxt = take ? (root_i | (ROOT_W'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

>>> rtl/core/plcg_div_cell.sv
// ----------------------------------------------------------------------------
// plcg_div_cell
// One quotient bit of the three-lane normal divider chain.
// ----------------------------------------------------------------------------
module plcg_div_cell #(
  parameter int BIT = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                vld_i,
  input  logic [plcg_pkg::ROOT_W-1:0]         len_i,
  input  logic [2:0][plcg_pkg::NUM_W-1:0]     rem_i,
  input  logic [2:0][plcg_pkg::QUOT_W-1:0]    q_i,
  input  plcg_pkg::dv_side_t                  side_i,
  output logic                                vld_o,
  output logic [plcg_pkg::ROOT_W-1:0]         len_o,
  output logic [2:0][plcg_pkg::NUM_W-1:0]     rem_o,
  output logic [2:0][plcg_pkg::QUOT_W-1:0]    q_o,
  output plcg_pkg::dv_side_t                  side_o
);
  import plcg_pkg::*;

  localparam int DW = ROOT_W + NORM_FRAC;

  logic [DW-1:0]            dvs;
  logic [2:0][NUM_W-1:0]    rem_nxt;
  logic [2:0][QUOT_W-1:0]   q_nxt;
  logic                     vld_r;
  logic [ROOT_W-1:0]        len_r;
  logic [2:0][NUM_W-1:0]    rem_r;
  logic [2:0][QUOT_W-1:0]   q_r;
  dv_side_t                 side_r;

  // Restoring division step on each lane.
  always_comb begin
    dvs = DW'(len_i) << BIT;
    for (int i = 0; i < 3; i++) begin
      if ({2'b00, rem_i[i]} >= dvs) begin
        rem_nxt[i] = NUM_W'({2'b00, rem_i[i]} - dvs);
        q_nxt[i]   = q_i[i] | (QUOT_W'(1) << BIT);
      end else begin
        rem_nxt[i] = rem_i[i];
        q_nxt[i]   = q_i[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_i;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign len_o  = len_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign side_o = side_r;

endmodule
